/* sv/pfpe_pkg.sv */
// Shared definitions for the page-organized framebuffer pixel engine.
// Holds default geometry, the item kind codes and the stream field widths.
// No dependencies.
package pfpe_pkg;

  localparam int WIDTH_DEF        = 128;
  localparam int HEIGHT_DEF       = 64;
  localparam int SYMBOL_WIDTH_DEF = 20;
  localparam int PAGE_ROWS        = 8;

  localparam int KIND_W     = 2;
  localparam int COORD_W    = 8;
  localparam int ROW_BITS_W = 21;
  localparam int BYTE_IDX_W = 10;
  localparam int PIXEL_W    = 8;

  // Packed input payload: x, y, row word, byte index, padded to whole bytes.
  localparam int IN_FIELDS_W = 2 * COORD_W + ROW_BITS_W + BYTE_IDX_W;
  localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR = 2'd0,
    KIND_PIXEL = 2'd1,
    KIND_ROW   = 2'd2,
    KIND_READ  = 2'd3
  } kind_t;

endpackage

/* sv/pfpe_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// Used for the frame store; no package dependency.
module pfpe_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/page_framebuffer_pixel_engine_core.sv */
// Page-organized monochrome framebuffer with a pixel engine; top level.
// Depends on pfpe_pkg and pfpe_ram.
// One transaction at a time. A set pixel walks one column and a symbol row
// SYMBOL_WIDTH columns (one frame store read-modify-write step per
// column, pipelined through the single read and write port); a read fetches
// its byte, and a clear sweeps the store at one byte per cycle.
// Reset: synchronous; afterwards the whole store, WIDTH * ceil(HEIGHT/8)
// bytes (1024 at the defaults), is swept to zero before input is taken.
module page_framebuffer_pixel_engine_core
  import pfpe_pkg::*;
#(
  parameter int WIDTH        = WIDTH_DEF,
  parameter int HEIGHT       = HEIGHT_DEF,
  parameter int SYMBOL_WIDTH = SYMBOL_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // Input stream.
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // s_tdata, from bit 0 up: x_coord[7:0], y_coord[7:0], row_bits[20:0],
  // byte_index[9:0], one zero pad bit.
  input  logic [IN_DATA_W-1:0] s_tdata,
  // s_tuser: kind[1:0].
  input  logic [KIND_W-1:0]    s_tuser,
  // Result stream.
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // m_tdata: read_byte[7:0].
  output logic [PIXEL_W-1:0]   m_tdata
);

  localparam int PAGES   = (HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
  localparam int STORE   = WIDTH * PAGES;
  localparam int AW      = $clog2(STORE);
  localparam int WW      = SYMBOL_WIDTH + 1;
  localparam int CW      = (SYMBOL_WIDTH > 1) ? $clog2(SYMBOL_WIDTH) : 1;
  localparam int COL_W   = COORD_W + 1;

  typedef enum logic [4:0] {
    ST_SWEEP = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_WALK  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_FETCH = 5'b10000
  } state_t;

  state_t state;

  // Unpacked input fields.
  logic [COORD_W-1:0]    in_x;
  logic [COORD_W-1:0]    in_y;
  logic [ROW_BITS_W-1:0] in_row;
  logic [BYTE_IDX_W-1:0] in_idx;
  kind_t                 in_kind;
  logic                  in_accept;
  logic                  in_oob;

  assign in_x    = s_tdata[COORD_W-1:0];
  assign in_y    = s_tdata[2*COORD_W-1:COORD_W];
  assign in_row  = s_tdata[2*COORD_W+ROW_BITS_W-1:2*COORD_W];
  assign in_idx  = s_tdata[IN_FIELDS_W-1:2*COORD_W+ROW_BITS_W];
  assign in_kind = kind_t'(s_tuser);

  assign s_tready  = (state == ST_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign in_oob    = !(int'(in_idx) < STORE);

  // Walk registers: the symbol word shifts left so its top bit is always
  // the pixel for the current column.
  logic [WW-1:0]      word;
  logic [COL_W-1:0]   col;
  logic [CW-1:0]      left;
  logic [AW-1:0]      row_base;
  logic               row_ok;
  logic [PIXEL_W-1:0] pix_mask;
  logic               rd_oob;
  logic [AW-1:0]      sweep_addr;

  // A pixel read issued in one cycle is written back in the next one.
  logic               pend_v;
  logic [AW-1:0]      pend_addr;

  logic               step_hit;
  logic [AW-1:0]      step_addr;

  assign step_hit  = (state == ST_WALK) && word[SYMBOL_WIDTH] && row_ok
                     && (int'(col) < WIDTH);
  assign step_addr = row_base + AW'(col);

  // Frame store ports.
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [PIXEL_W-1:0] ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [PIXEL_W-1:0] ram_rdata;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pend_addr;
    ram_wdata = ram_rdata | pix_mask;
    if (state == ST_SWEEP) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_addr;
      ram_wdata = '0;
    end else if (state == ST_WALK || state == ST_DRAIN) begin
      ram_we = pend_v;
    end
  end

  always_comb begin
    if (state == ST_WALK) begin
      ram_re    = step_hit;
      ram_raddr = step_addr;
    end else begin
      ram_re    = in_accept && (in_kind == KIND_READ) && !in_oob;
      ram_raddr = AW'(in_idx);
    end
  end

  pfpe_ram #(
    .DATA_W (PIXEL_W),
    .DEPTH  (STORE)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic out_load;
  assign out_load = (state == ST_FETCH) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_SWEEP;
      sweep_addr <= '0;
      pend_v     <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end

      unique case (state)
        ST_SWEEP: begin
          if (sweep_addr == AW'(STORE - 1)) begin
            state <= ST_IDLE;
          end
          sweep_addr <= sweep_addr + 1'b1;
        end
        ST_IDLE: begin
          pend_v <= 1'b0;
          if (in_accept) begin
            col <= COL_W'(in_x);
            unique case (in_kind)
              KIND_CLEAR: begin
                sweep_addr <= '0;
                state      <= ST_SWEEP;
              end
              KIND_PIXEL: begin
                word  <= WW'(1) << SYMBOL_WIDTH;
                left  <= '0;
                state <= ST_WALK;
              end
              KIND_ROW: begin
                word  <= WW'(in_row);
                left  <= CW'(SYMBOL_WIDTH - 1);
                state <= ST_WALK;
              end
              KIND_READ: begin
                rd_oob <= in_oob;
                state  <= ST_FETCH;
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_WALK: begin
          pend_v    <= step_hit;
          pend_addr <= step_addr;
          word      <= word << 1;
          col       <= col + 1'b1;
          left      <= left - 1'b1;
          if (left == '0) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          pend_v <= 1'b0;
          state  <= ST_IDLE;
        end
        ST_FETCH: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Payload registers loaded on acceptance and on result delivery.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      row_ok   <= int'(in_y) < HEIGHT;
      row_base <= AW'(int'(in_y >> $clog2(PAGE_ROWS)) * WIDTH);
      pix_mask <= PIXEL_W'(1) << in_y[$clog2(PAGE_ROWS)-1:0];
    end
    if (out_load) begin
      m_tdata <= rd_oob ? '0 : ram_rdata;
    end
  end

  // The engine only writes inside the store.
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (int'(ram_waddr) < STORE))
    else $error("frame store write beyond the store");

  // Columns of one walk are distinct, so a write never meets the read.
  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("frame store read and write to the same byte");

  // An accepted read moves straight to fetching its byte.
  a_read_fetch: assert property (@(posedge clk) disable iff (rst)
    (in_accept && (in_kind == KIND_READ)) |=> (state == ST_FETCH))
    else $error("read transaction did not enter fetch");

endmodule

/* bench/page_framebuffer_pixel_engine_core_tb.sv */
// Self-checking bench for page_framebuffer_pixel_engine_core. It drives pixel, symbol row,
// clear and read transactions and checks every read against a shadow copy of the frame store.
// Depends on pfpe_pkg and the engine RTL only.
`timescale 1ns / 100ps

module page_framebuffer_pixel_engine_core_tb;
  import pfpe_pkg::*;

  localparam int STORE_BYTES = WIDTH_DEF * ((HEIGHT_DEF + PAGE_ROWS - 1) / PAGE_ROWS);
  // A clear walks the whole store, so the quiet tail after the last result covers it.
  localparam int TAIL_CYCLES = STORE_BYTES + 64;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 300;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic [KIND_W-1:0]    s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [PIXEL_W-1:0]   m_tdata;

  // Shadow frame store and the read results still owed by the block.
  logic [PIXEL_W-1:0] shadow_frame [STORE_BYTES];
  logic [PIXEL_W-1:0] pending_read_bytes [$];

  int send_gap_pct = 0;
  int ready_stall_pct = 0;
  bit hold_on = 1'b0;
  int error_count = 0;
  int cycle_count = 0;
  int recent_index = 0;

  page_framebuffer_pixel_engine_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off while hold_on is set.
  always @(posedge clk) begin
    m_tready <= !hold_on && ($urandom_range(99) >= ready_stall_pct);
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h", cycle_count, what, got, want);
    error_count++;
  endtask

  // Every result transaction is checked against the oldest outstanding read.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_read_bytes.size() == 0) begin
        report_mismatch("unexpected read_byte", int'(m_tdata), 0);
      end else begin
        if (m_tdata !== pending_read_bytes[0]) begin
          report_mismatch("read_byte", int'(m_tdata), int'(pending_read_bytes[0]));
        end
        void'(pending_read_bytes.pop_front());
      end
    end
  end

  // Pixels outside the image are dropped; column sums do not wrap.
  task automatic shadow_plot(input int px, input int py);
    int idx;
    if (px < WIDTH_DEF && py < HEIGHT_DEF) begin
      idx = px + (py / PAGE_ROWS) * WIDTH_DEF;
      shadow_frame[idx][py % PAGE_ROWS] = 1'b1;
      recent_index = idx;
    end
  endtask

  task automatic update_shadow_frame(input kind_t k, input logic [7:0] x, input logic [7:0] y,
                                     input logic [20:0] row, input logic [9:0] bidx);
    case (k)
      KIND_CLEAR: begin
        foreach (shadow_frame[i]) shadow_frame[i] = '0;
      end
      KIND_PIXEL: begin
        shadow_plot(int'(x), int'(y));
      end
      KIND_ROW: begin
        // Bit SYMBOL_WIDTH-j selects column x+j; bit 0 and bits above are ignored.
        for (int j = 0; j < SYMBOL_WIDTH_DEF; j++) begin
          if (row[SYMBOL_WIDTH_DEF - j]) shadow_plot(int'(x) + j, int'(y));
        end
      end
      default: begin
        pending_read_bytes.push_back(int'(bidx) < STORE_BYTES ? shadow_frame[bidx] : 8'h00);
      end
    endcase
  endtask

  task automatic send_item(input kind_t k, input logic [7:0] x, input logic [7:0] y,
                           input logic [20:0] row, input logic [9:0] bidx);
    while ($urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= k;
    s_tdata  <= {{(IN_DATA_W - IN_FIELDS_W){1'b0}}, bidx, row, y, x};
    do @(posedge clk); while (!s_tready);
    update_shadow_frame(k, x, y, row, bidx);
  endtask

  // Directed items fill the fields a kind ignores with random values.
  task automatic send_pixel(input logic [7:0] x, input logic [7:0] y);
    send_item(KIND_PIXEL, x, y, 21'($urandom), 10'($urandom));
  endtask

  task automatic send_row(input logic [7:0] x, input logic [7:0] y, input logic [20:0] row);
    send_item(KIND_ROW, x, y, row, 10'($urandom));
  endtask

  task automatic send_read(input logic [9:0] bidx);
    send_item(KIND_READ, 8'($urandom), 8'($urandom), 21'($urandom), bidx);
  endtask

  task automatic send_clear();
    send_item(KIND_CLEAR, 8'($urandom), 8'($urandom), 21'($urandom), 10'($urandom));
  endtask

  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    while (pending_read_bytes.size() != 0) @(posedge clk);
  endtask

  task automatic test_corner_cases();
    send_read(10'd0);
    send_read(10'd1023);
    send_pixel(8'd0, 8'd0);
    send_pixel(8'd127, 8'd63);
    send_pixel(8'd128, 8'd5);
    send_pixel(8'd3, 8'd64);
    send_pixel(8'd255, 8'd255);
    send_read(10'd0);
    send_read(10'd1023);
    send_read(10'd5);
    // Full row: all twenty columns of page one, row eight.
    send_row(8'd0, 8'd8, 21'h1FFFFF);
    // Overhang past the right edge, then a row fully off to the right.
    send_row(8'd120, 8'd9, 21'h1FFFFE);
    send_row(8'd250, 8'd10, 21'h1FFFFE);
    // Below the image, and a word holding only the unused bit 0.
    send_row(8'd0, 8'd64, 21'h1FFFFE);
    send_row(8'd40, 8'd20, 21'h000001);
    send_row(8'd60, 8'd33, 21'h155554);
    send_read(10'd128);
    send_read(10'd147);
    send_read(10'd255);
    send_read(10'd296);
    send_read(10'd316);
    send_clear();
    send_read(10'd0);
    send_read(10'd1023);
    send_read(10'd128);
    wait_for_results();
  endtask

  task automatic random_item();
    int sel;
    logic [7:0] x, y;
    logic [20:0] row;
    logic [9:0] bidx;
    sel = $urandom_range(99);
    x = 8'(($urandom_range(4) == 0) ? $urandom_range(255) : $urandom_range(WIDTH_DEF - 1));
    y = 8'(($urandom_range(4) == 0) ? $urandom_range(255) : $urandom_range(HEIGHT_DEF - 1));
    row = 21'($urandom);
    // Half the reads land next to a recently drawn byte so they see nonzero data.
    if ($urandom_range(1) == 0) bidx = 10'($urandom_range(1023));
    else bidx = 10'((recent_index + $urandom_range(2)) % STORE_BYTES);
    if (sel < 1) send_item(KIND_CLEAR, x, y, row, bidx);
    else if (sel < 31) send_item(KIND_PIXEL, x, y, row, bidx);
    else if (sel < 66) send_item(KIND_ROW, x, y, row, bidx);
    else send_item(KIND_READ, x, y, row, bidx);
  endtask

  // The result side holds off while reads keep coming, so the engine backs up
  // and stops taking input; afterwards the sender waits for all results.
  task automatic test_backpressure();
    send_gap_pct = 0;
    ready_stall_pct = 0;
    fork
      begin
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
      end
      begin
        for (int i = 0; i < 40; i++) begin
          if (i % 4 == 0) random_item();
          else send_read(10'($urandom_range(1023)));
        end
      end
    join
    wait_for_results();
  endtask

  task automatic test_random_traffic(input int count, input int gap_pct, input int stall_pct);
    send_gap_pct = gap_pct;
    ready_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) random_item();
    wait_for_results();
  endtask

  initial begin
    foreach (shadow_frame[i]) shadow_frame[i] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_corner_cases();
    test_backpressure();
    test_random_traffic(445, 0, 0);
    test_random_traffic(445, 49, 0);
    test_random_traffic(445, 0, 49);
    test_random_traffic(445, 10, 10);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* files.f */
sv/pfpe_pkg.sv
sv/pfpe_ram.sv
sv/page_framebuffer_pixel_engine_core.sv
bench/page_framebuffer_pixel_engine_core_tb.sv
